@@ rtl/core/rbp_pkg.sv @@
`default_nettype none

package rbp_pkg;

  // Field widths fixed by the pixel format and the register map
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned OFS_W     = 24;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MODE_W    = 3;

  // Blend table geometry
  localparam int unsigned TBL_DEPTH = 65536;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);

  // Default coordinate counter width
  localparam int unsigned COORD_BITS_DEF = 12;

  // Pixel combine modes
  typedef enum logic [MODE_W-1:0] {
    MODE_FILL         = 3'd0,
    MODE_COPY         = 3'd1,
    MODE_KEY          = 3'd2,
    MODE_BLEND_DST_HI = 3'd3,
    MODE_BLEND_SRC_HI = 3'd4
  } mode_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_SRC_WIDTH  = 3'd1,
    REG_COPY_WIDTH = 3'd2,
    REG_DST_STRIDE = 3'd3,
    REG_ROWS       = 3'd4,
    REG_KEY_PIXEL  = 3'd5,
    REG_FILL_PIXEL = 3'd6
  } cfg_reg_e;

  // Input item actions
  localparam logic ACT_TABLE_WRITE = 1'b0;
  localparam logic ACT_PIXEL       = 1'b1;

  // Register reset values
  localparam logic [MODE_W-1:0] RST_MODE       = MODE_COPY;
  localparam logic [CFG_W-1:0]  RST_SRC_WIDTH  = 12'd320;
  localparam logic [CFG_W-1:0]  RST_COPY_WIDTH = 12'd320;
  localparam logic [CFG_W-1:0]  RST_DST_STRIDE = 12'd320;
  localparam logic [CFG_W-1:0]  RST_ROWS       = 12'd200;
  localparam logic [PIX_W-1:0]  RST_KEY_PIXEL  = 8'd0;
  localparam logic [PIX_W-1:0]  RST_FILL_PIXEL = 8'd0;

endpackage

`default_nettype wire

@@ rtl/core/rbp_if.sv @@
`default_nettype none

// Configuration write channel
interface rbp_cfg_if import rbp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// Input item channel: table writes and pixels
interface rbp_in_if import rbp_pkg::*;;
  logic              valid;
  logic              ready;
  logic              action;
  logic [TBL_AW-1:0] table_index;
  logic [PIX_W-1:0]  table_value;
  logic [PIX_W-1:0]  src_pixel;
  logic [PIX_W-1:0]  dst_pixel;

  modport source (output valid, output action, output table_index, output table_value,
                  output src_pixel, output dst_pixel, input ready);
  modport sink   (input valid, input action, input table_index, input table_value,
                  input src_pixel, input dst_pixel, output ready);
endinterface

// Result channel: one per pixel
interface rbp_out_if import rbp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OFS_W-1:0] dest_offset;
  logic [PIX_W-1:0] pixel_out;
  logic             write_enable;
  logic             last;

  modport source (output valid, output dest_offset, output pixel_out,
                  output write_enable, output last, input ready);
  modport sink   (input valid, input dest_offset, input pixel_out,
                  input write_enable, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/raster_blit_pixel_engine.sv @@
`default_nettype none

// Rectangle blitter for 8-bit palette pixels.
// cfg_i takes register writes (mode, widths, stride, rows, key and fill color);
// it is always ready. Write it only while no pixel is in flight.
// in_i carries table-write items (action 0) that load one blend table entry,
// and pixel items (action 1) with the source pixel and the destination pixel
// currently at the offset reported for it. Table writes give no result.
// out_o gives one transaction per pixel: destination offset, new pixel,
// write strobe and a last flag on the final pixel of the rectangle.
// A pixel passes the synchronous blend table read (stage 1) and then the
// output register before it shows on out_o.
// Throughput is one item per cycle while out_o is not stalled; the single-port
// table memory takes either one write or one read each cycle, which one item needs.
// A full output register stalled by out_o.ready keeps its result; one more
// pixel parks in the table-read stage, after which in_i.ready drops.
// Reset clears counters and pipeline valids and loads the register defaults;
// the blend table contents are undefined until written.
module raster_blit_pixel_engine import rbp_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rbp_cfg_if.sink     cfg_i,
  rbp_in_if.sink      in_i,
  rbp_out_if.source   out_o
);

  localparam int unsigned CMP_W = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 1;

  typedef struct packed {
    logic [OFS_W-1:0] offset;
    logic [PIX_W-1:0] pix;
    logic             we;
    logic             last;
    logic             use_tbl;
  } s1_t;

  // Configuration registers
  logic [MODE_W-1:0] mode_q;
  logic [CFG_W-1:0]  src_width_q, copy_width_q, dst_stride_q, rows_q;
  logic [PIX_W-1:0]  key_pixel_q, fill_pixel_q;

  // Raster counters
  logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;
  logic [OFS_W-1:0]      row_base_q, row_base_d;

  // Pipeline
  logic             s1_valid_q, out_valid_q;
  s1_t              s1_q, s1_d;
  logic [PIX_W-1:0] tbl_rdata_q;
  logic [PIX_W-1:0] tbl_mem [TBL_DEPTH];
  logic [TBL_AW-1:0] tbl_raddr;

  logic [OFS_W-1:0] out_offset_q;
  logic [PIX_W-1:0] out_pix_q;
  logic             out_we_q, out_last_q;

  logic in_acc, pix_acc, tbl_wr, s1_move, out_free;

  logic [CMP_W-1:0] col_ext, sw_ext, rows_ext, row_ext;
  logic             row_end, rect_end, we_col;

  // Handshake control
  assign out_free = !out_valid_q || out_o.ready;
  assign s1_move  = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_acc   = in_i.valid && in_i.ready;
  assign pix_acc  = in_acc && (in_i.action == ACT_PIXEL);
  assign tbl_wr   = in_acc && (in_i.action == ACT_TABLE_WRITE);
  assign cfg_i.ready = 1'b1;

  // Raster position and row/rectangle end detection
  always_comb begin
    col_ext  = CMP_W'(col_q);
    row_ext  = CMP_W'(row_q);
    sw_ext   = (src_width_q == '0) ? CMP_W'(1) : CMP_W'(src_width_q);
    rows_ext = (rows_q == '0) ? CMP_W'(1) : CMP_W'(rows_q);
    row_end  = (col_ext + CMP_W'(1)) >= sw_ext;
    rect_end = row_end && ((row_ext + CMP_W'(1)) >= rows_ext);
    we_col   = col_ext < CMP_W'(copy_width_q);

    col_d      = col_q + COORD_BITS'(1);
    row_d      = row_q;
    row_base_d = row_base_q;
    if (rect_end) begin
      col_d      = '0;
      row_d      = '0;
      row_base_d = '0;
    end else if (row_end) begin
      col_d      = '0;
      row_d      = row_q + COORD_BITS'(1);
      row_base_d = row_base_q + OFS_W'(dst_stride_q);
    end
  end

  // Decode mode into the stage-1 result and table address
  always_comb begin
    s1_d.offset  = row_base_q + OFS_W'(col_q);
    s1_d.last    = rect_end;
    s1_d.we      = we_col;
    s1_d.pix     = in_i.src_pixel;
    s1_d.use_tbl = 1'b0;
    tbl_raddr    = {in_i.src_pixel, in_i.dst_pixel};
    unique case (mode_q)
      MODE_FILL: s1_d.pix = fill_pixel_q;
      MODE_KEY: begin
        if (in_i.src_pixel == key_pixel_q) s1_d.we = 1'b0;
      end
      MODE_BLEND_DST_HI: begin
        s1_d.use_tbl = 1'b1;
        tbl_raddr    = {in_i.dst_pixel, in_i.src_pixel};
      end
      MODE_BLEND_SRC_HI: s1_d.use_tbl = 1'b1;
      default: s1_d.pix = in_i.src_pixel;
    endcase
    if (!s1_d.we) begin
      s1_d.pix     = in_i.dst_pixel;
      s1_d.use_tbl = 1'b0;
    end
  end

  // Blend table: one write or one read per cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (tbl_wr) tbl_mem[in_i.table_index] <= in_i.table_value;
    if (pix_acc) tbl_rdata_q <= tbl_mem[tbl_raddr];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= RST_MODE;
      src_width_q  <= RST_SRC_WIDTH;
      copy_width_q <= RST_COPY_WIDTH;
      dst_stride_q <= RST_DST_STRIDE;
      rows_q       <= RST_ROWS;
      key_pixel_q  <= RST_KEY_PIXEL;
      fill_pixel_q <= RST_FILL_PIXEL;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_MODE:       mode_q       <= cfg_i.data[MODE_W-1:0];
        REG_SRC_WIDTH:  src_width_q  <= cfg_i.data;
        REG_COPY_WIDTH: copy_width_q <= cfg_i.data;
        REG_DST_STRIDE: dst_stride_q <= cfg_i.data;
        REG_ROWS:       rows_q       <= cfg_i.data;
        REG_KEY_PIXEL:  key_pixel_q  <= cfg_i.data[PIX_W-1:0];
        REG_FILL_PIXEL: fill_pixel_q <= cfg_i.data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance counters on each accepted pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      row_base_q <= '0;
    end else if (pix_acc) begin
      col_q      <= col_d;
      row_q      <= row_d;
      row_base_q <= row_base_d;
    end
  end

  // Stage 1: wait for table read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= pix_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) s1_q <= s1_d;
  end

  // Output register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_offset_q <= s1_q.offset;
      out_pix_q    <= s1_q.use_tbl ? tbl_rdata_q : s1_q.pix;
      out_we_q     <= s1_q.we;
      out_last_q   <= s1_q.last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.dest_offset  = out_offset_q;
  assign out_o.pixel_out    = out_pix_q;
  assign out_o.write_enable = out_we_q;
  assign out_o.last         = out_last_q;

endmodule

`default_nettype wire

@@ rtl/core/rbp_checker.sv @@
`default_nettype none

module rbp_checker import rbp_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             in_action_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [OFS_W-1:0] out_dest_offset_i,
  input wire logic [PIX_W-1:0] out_pixel_out_i,
  input wire logic             cfg_ready_i
);

  logic pix_acc;
  assign pix_acc = in_valid_i && in_ready_i && (in_action_i == ACT_PIXEL);

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_dest_offset_i)
      && $stable(out_pixel_out_i))
    else $error("result changed while stalled");

  // Input backpressure only when the output register is full
  a_ready_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty output");

  // A result appearing on an idle output comes from an accepted pixel that passed stage 1
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(pix_acc, 2))
    else $error("result without matching pixel");

  // Register writes are never stalled
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration port stalled");

endmodule

bind raster_blit_pixel_engine rbp_checker u_rbp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_action_i       (in_i.action),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_dest_offset_i (out_o.dest_offset),
  .out_pixel_out_i   (out_o.pixel_out),
  .cfg_ready_i       (cfg_i.ready)
);

`default_nettype wire

@@ dv/rbp_blit_checker.sv @@
// Watch the three channels, predict every pixel result and compare it with the
// result transaction that the engine hands out.
module rbp_blit_checker import rbp_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rbp_cfg_if          cfg_ch,
  rbp_in_if           item_ch,
  rbp_out_if          res_ch,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [OFS_W-1:0] dest_offset;
    logic [PIX_W-1:0] pixel_out;
    logic             write_enable;
    logic             last;
  } blit_result_t;

  // Register shadows
  logic [MODE_W-1:0] mode_q;
  logic [CFG_W-1:0]  src_width_q;
  logic [CFG_W-1:0]  copy_width_q;
  logic [CFG_W-1:0]  dst_stride_q;
  logic [CFG_W-1:0]  rows_q;
  logic [PIX_W-1:0]  key_pixel_q;
  logic [PIX_W-1:0]  fill_pixel_q;

  // Raster position inside the rectangle
  logic [COORD_BITS-1:0] column_q;
  logic [COORD_BITS-1:0] row_q;
  logic [OFS_W-1:0]      row_base_q;

  logic [PIX_W-1:0] blend_lut [TBL_DEPTH];

  blit_result_t pixel_results_q [$];
  int unsigned  mismatches;

  // Work out the result of one pixel and step the raster position
  function automatic blit_result_t blit_pixel(logic [PIX_W-1:0] src, logic [PIX_W-1:0] dst);
    blit_result_t res;
    int unsigned  span;
    int unsigned  height;
    res.dest_offset  = row_base_q + OFS_W'(column_q);
    res.write_enable = 32'(column_q) < 32'(copy_width_q);
    case (mode_q)
      MODE_FILL: res.pixel_out = fill_pixel_q;
      MODE_KEY: begin
        res.pixel_out = src;
        // transparent color leaves the destination alone
        if (src == key_pixel_q) res.write_enable = 1'b0;
      end
      MODE_BLEND_DST_HI: res.pixel_out = blend_lut[{dst, src}];
      MODE_BLEND_SRC_HI: res.pixel_out = blend_lut[{src, dst}];
      default: res.pixel_out = src;
    endcase
    if (!res.write_enable) res.pixel_out = dst;

    // Zero width or height behaves as one
    span     = (src_width_q == '0) ? 32'd1 : 32'(src_width_q);
    height   = (rows_q == '0) ? 32'd1 : 32'(rows_q);
    res.last = 1'b0;
    if (32'(column_q) + 32'd1 >= span) begin
      column_q = '0;
      if (32'(row_q) + 32'd1 >= height) begin
        res.last   = 1'b1;
        row_q      = '0;
        row_base_q = '0;
      end else begin
        row_q      = row_q + COORD_BITS'(1);
        row_base_q = row_base_q + OFS_W'(dst_stride_q);
      end
    end else begin
      column_q = column_q + COORD_BITS'(1);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    blit_result_t got;
    blit_result_t want;
    if (!rst_ni) begin
      mode_q       = RST_MODE;
      src_width_q  = RST_SRC_WIDTH;
      copy_width_q = RST_COPY_WIDTH;
      dst_stride_q = RST_DST_STRIDE;
      rows_q       = RST_ROWS;
      key_pixel_q  = RST_KEY_PIXEL;
      fill_pixel_q = RST_FILL_PIXEL;
      column_q     = '0;
      row_q        = '0;
      row_base_q   = '0;
      pixel_results_q.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Match the result first, so it never pairs with a pixel taken at this edge
      if (res_ch.valid && res_ch.ready) begin
        got.dest_offset  = res_ch.dest_offset;
        got.pixel_out    = res_ch.pixel_out;
        got.write_enable = res_ch.write_enable;
        got.last         = res_ch.last;
        if (pixel_results_q.size() == 0) begin
          $error("result transaction with no pixel outstanding: dest_offset %0h",
                 got.dest_offset);
          mismatches++;
        end else begin
          want = pixel_results_q.pop_front();
          if (got.dest_offset !== want.dest_offset) begin
            $error("dest_offset: expected %0h, actual %0h", want.dest_offset, got.dest_offset);
            mismatches++;
          end
          if (got.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %0h, actual %0h", want.pixel_out, got.pixel_out);
            mismatches++;
          end
          if (got.write_enable !== want.write_enable) begin
            $error("write_enable: expected %0b, actual %0b", want.write_enable,
                   got.write_enable);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            mismatches++;
          end
        end
      end

      // Track register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_MODE:       mode_q       = cfg_ch.data[MODE_W-1:0];
          REG_SRC_WIDTH:  src_width_q  = cfg_ch.data;
          REG_COPY_WIDTH: copy_width_q = cfg_ch.data;
          REG_DST_STRIDE: dst_stride_q = cfg_ch.data;
          REG_ROWS:       rows_q       = cfg_ch.data;
          REG_KEY_PIXEL:  key_pixel_q  = cfg_ch.data[PIX_W-1:0];
          REG_FILL_PIXEL: fill_pixel_q = cfg_ch.data[PIX_W-1:0];
          default: ;
        endcase
      end

      // Load the table or queue the predicted pixel
      if (item_ch.valid && item_ch.ready) begin
        if (item_ch.action == ACT_TABLE_WRITE) begin
          blend_lut[item_ch.table_index] = item_ch.table_value;
        end else begin
          pixel_results_q.push_back(blit_pixel(item_ch.src_pixel, item_ch.dst_pixel));
        end
      end

      fail_count_o <= mismatches;
      pending_o    <= pixel_results_q.size();
    end
  end

endmodule

@@ dv/tb_raster_blit_pixel_engine.sv @@
module tb_raster_blit_pixel_engine;
  import rbp_pkg::*;

  localparam int unsigned RANDOM_PHASES = 26;
  localparam int unsigned PHASE_ITEMS   = 50;
  localparam int unsigned LONG_HOLD     = 80;
  // Mode code past the named ones, expected to act as a plain copy
  localparam logic [MODE_W-1:0] MODE_SPARE_COPY = 3'd7;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int unsigned fail_count;
  int unsigned pending;

  // Idling controls; the receiver reads the last two
  bit          sender_gaps;
  bit          receiver_stalls;
  int unsigned pressure_req;

  // What the stimulus has programmed so far
  logic [MODE_W-1:0] cur_mode;
  logic [PIX_W-1:0]  cur_key;
  bit                lut_loaded [TBL_DEPTH];
  logic [TBL_AW-1:0] loaded_entries [$];
  int unsigned       pixel_count;
  int unsigned       load_count;

  rbp_cfg_if cfg_ch ();
  rbp_in_if  item_ch ();
  rbp_out_if res_ch ();

  raster_blit_pixel_engine DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .in_i   (item_ch),
    .out_o  (res_ch)
  );

  rbp_blit_checker blit_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_ch       (cfg_ch),
    .item_ch      (item_ch),
    .res_ch       (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk = ~clk;

  // Watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Offer one item transaction, holding it until the engine takes it
  task automatic offer_item(logic action, logic [TBL_AW-1:0] tidx, logic [PIX_W-1:0] tval,
                            logic [PIX_W-1:0] src, logic [PIX_W-1:0] dst);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.action      <= action;
    item_ch.table_index <= tidx;
    item_ch.table_value <= tval;
    item_ch.src_pixel   <= src;
    item_ch.dst_pixel   <= dst;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic load_entry(logic [TBL_AW-1:0] idx, logic [PIX_W-1:0] val);
    offer_item(ACT_TABLE_WRITE, idx, val, PIX_W'($urandom), PIX_W'($urandom));
    if (!lut_loaded[idx]) begin
      lut_loaded[idx] = 1'b1;
      loaded_entries.push_back(idx);
    end
    load_count++;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] src, logic [PIX_W-1:0] dst);
    offer_item(ACT_PIXEL, TBL_AW'($urandom), PIX_W'($urandom), src, dst);
    pixel_count++;
  endtask

  // Write one register; only called while the engine is idle
  task automatic cfg_write(cfg_reg_e idx, logic [CFG_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_MODE) cur_mode = val[MODE_W-1:0];
    if (idx == REG_KEY_PIXEL) cur_key = val[PIX_W-1:0];
  endtask

  // Close the stream, wait out every outstanding pixel, then the pipeline
  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly small dimensions, sometimes zero or full range
  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return CFG_W'($urandom_range(1, 12));
    endcase
  endfunction

  // Receiver: random stall bursts plus long hold-offs on request
  initial begin
    int unsigned holds_served;
    holds_served = 0;
    res_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (pressure_req != holds_served) begin
        holds_served++;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    logic [TBL_AW-1:0] pick;
    logic [PIX_W-1:0]  src;
    logic [PIX_W-1:0]  dst;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_MODE;
    cfg_ch.data         = '0;
    item_ch.valid       = 1'b0;
    item_ch.action      = ACT_PIXEL;
    item_ch.table_index = '0;
    item_ch.table_value = '0;
    item_ch.src_pixel   = '0;
    item_ch.dst_pixel   = '0;
    sender_gaps         = 1'b1;
    receiver_stalls     = 1'b1;
    pressure_req        = 0;
    cur_mode            = RST_MODE;
    cur_key             = RST_KEY_PIXEL;
    pixel_count         = 0;
    load_count          = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill a 3x2 rectangle with only two columns written
    cfg_write(REG_MODE, CFG_W'(MODE_FILL));
    cfg_write(REG_SRC_WIDTH, 12'd3);
    cfg_write(REG_COPY_WIDTH, 12'd2);
    cfg_write(REG_DST_STRIDE, 12'd4095);
    cfg_write(REG_ROWS, 12'd2);
    cfg_write(REG_KEY_PIXEL, 12'h80);
    cfg_write(REG_FILL_PIXEL, 12'hFF);
    for (int k = 0; k < 6; k++) send_pixel(k[0] ? 8'hFF : 8'h00, k[1] ? 8'h00 : 8'hFF);

    // Load the table corners, then read them back through both blend orders
    load_entry(16'h0000, 8'hA5);
    load_entry(16'hFFFF, 8'h5A);
    load_entry(16'h00FF, 8'h3C);
    load_entry(16'hFF00, 8'hC3);
    drain();
    cfg_write(REG_COPY_WIDTH, 12'd4095);
    for (int m = 0; m < 2; m++) begin
      drain();
      cfg_write(REG_MODE, CFG_W'(m ? MODE_BLEND_SRC_HI : MODE_BLEND_DST_HI));
      for (int k = 0; k < 4; k++) send_pixel({PIX_W{k[0]}}, {PIX_W{k[1]}});
    end

    // Color key hit and miss
    drain();
    cfg_write(REG_MODE, CFG_W'(MODE_KEY));
    send_pixel(8'h80, 8'h12);
    send_pixel(8'h7F, 8'h34);

    // Spare mode code copies
    drain();
    cfg_write(REG_MODE, CFG_W'(MODE_SPARE_COPY));
    send_pixel(8'h69, 8'h96);

    // Zero width and rows end the rectangle on every pixel
    drain();
    cfg_write(REG_SRC_WIDTH, '0);
    cfg_write(REG_ROWS, '0);
    send_pixel(8'h01, 8'hFE);

    // Shrink the width under the current column mid-row
    drain();
    cfg_write(REG_SRC_WIDTH, 12'd8);
    cfg_write(REG_ROWS, 12'd3);
    for (int k = 0; k < 3; k++) send_pixel(PIX_W'($urandom), PIX_W'($urandom));
    drain();
    cfg_write(REG_SRC_WIDTH, 12'd1);
    send_pixel(8'h42, 8'h24);

    // Random phases: new settings, then a mixed stream of pixels and table loads
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      sender_gaps = (p < RANDOM_PHASES - 4) && $urandom_range(0, 3) != 0;
      receiver_stalls <= (p < RANDOM_PHASES - 4) && $urandom_range(0, 3) != 0;
      if (p == 0 || $urandom_range(0, 1)) cfg_write(REG_MODE, CFG_W'($urandom_range(0, 7)));
      if (p == 0 || $urandom_range(0, 1)) cfg_write(REG_SRC_WIDTH, pick_dim());
      if (p == 0 || $urandom_range(0, 1)) cfg_write(REG_COPY_WIDTH, pick_dim());
      if (p == 0 || $urandom_range(0, 1)) begin
        cfg_write(REG_DST_STRIDE, (p % 5 == 0) ? pick_dim() : CFG_W'($urandom));
      end
      if (p == 0 || $urandom_range(0, 1)) cfg_write(REG_ROWS, pick_dim());
      if (p == 0 || $urandom_range(0, 2) == 0) begin
        cfg_write(REG_KEY_PIXEL, CFG_W'($urandom_range(0, 255)));
      end
      if (p == 0 || $urandom_range(0, 2) == 0) begin
        cfg_write(REG_FILL_PIXEL, CFG_W'($urandom_range(0, 255)));
      end

      // Hold the receiver off while items keep coming, so the engine backs up
      if (p == 6 || p == 17) begin
        sender_gaps = 1'b0;
        pressure_req <= pressure_req + 1;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 6) == 0) begin
          load_entry(TBL_AW'($urandom), PIX_W'($urandom));
        end else begin
          src = PIX_W'($urandom);
          dst = PIX_W'($urandom);
          // Blend lookups only ever hit loaded entries
          if (cur_mode == MODE_BLEND_DST_HI || cur_mode == MODE_BLEND_SRC_HI) begin
            pick = loaded_entries[$urandom_range(0, loaded_entries.size() - 1)];
            if (cur_mode == MODE_BLEND_DST_HI) {dst, src} = pick;
            else {src, dst} = pick;
          end else if (cur_mode == MODE_KEY && $urandom_range(0, 3) == 0) begin
            src = cur_key;
          end
          send_pixel(src, dst);
        end
      end
    end

    drain();
    $display("Streamed %0d pixels and %0d blend table loads over %0d register phases,",
             pixel_count, load_count, RANDOM_PHASES + 8);
    $display("with %0d long output hold-offs and all mode codes and edge dimensions.",
             pressure_req);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
